// ===== design/stcs_pkg.sv =====
`default_nettype none

package stcs_pkg;

	// Default width of the signed sample fields.
	localparam int SAMPLE_BITS_DEF = 32;

	// Shared multiplier operand width and product width.
	localparam int MUL_W = 32;
	localparam int PROD_W = 2 * MUL_W;

	// Divider: 64-bit dividend (the square), 32-bit divisor (nu).
	localparam int DVD_W = 64;
	localparam int DVS_W = 32;
	localparam int DIV_CNT_W = $clog2(DVD_W);

	// Accumulator and log widths.
	localparam int SUM_W = 48;
	localparam int FRAC_W = 16;
	localparam int LN_W = 22;
	localparam int SHF_W = 6;

	// Fixed-point constants.
	localparam logic [DVD_W-1:0] ONE_Q16 = 64'd65536;
	localparam logic [MUL_W-1:0] LN2_Q32 = 32'd2977044472;
	localparam logic [DVS_W-1:0] NU_RESET = 32'd65536;
	localparam logic [SHF_W-1:0] K_OFS = 6'd47;

endpackage

`default_nettype wire

// ===== design/student_t_robust_cost_sum_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    data_sample, model_sample, last_sample
// out       output     out_valid / out_ready  cost_sum, saturated
// cfg       input      cfg_valid / cfg_ready  cfg_nu
//
// Each pair runs from transfer to the next in_ready through the 64-step
// restoring divider, then 6 normalize steps, log squaring on the shared
// multiplier and the rounding and accumulate steps.
// Reset sets nu to 1.0 and clears the running sum and clip flag.
// A finished sum waits in the output register while the next pair is taken;
// a last pair stalls in its accumulate step only while that register is full.

module student_t_robust_cost_sum_unit
	import stcs_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire signed [SAMPLE_BITS-1:0] data_sample,
	input  wire signed [SAMPLE_BITS-1:0] model_sample,
	input  wire                          last_sample,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [SUM_W-1:0]             cost_sum,
	output logic                         saturated,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [DVS_W-1:0]             cfg_nu
);

	localparam int DW = SAMPLE_BITS + 1;
	localparam int MAGW = (DW > MUL_W + 1) ? DW : MUL_W + 1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SQ   = 9'b000000010,
		ST_DIVS = 9'b000000100,
		ST_DIV  = 9'b000001000,
		ST_NORM = 9'b000010000,
		ST_LOG  = 9'b000100000,
		ST_LN   = 9'b001000000,
		ST_LNR  = 9'b010000000,
		ST_ACC  = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [4:0]         cnt_q;
	logic [SAMPLE_BITS-1:0] data_q;
	logic [SAMPLE_BITS-1:0] model_q;
	logic               last_q;
	logic [DVD_W-1:0]   yn_q;
	logic [SHF_W-1:0]   shf_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [LN_W-1:0]    lnv_q;
	logic [SUM_W-1:0]   sum_q;
	logic               clip_q;
	logic [DVS_W-1:0]   nu_q;
	logic               out_valid_q;
	logic [SUM_W-1:0]   cost_q;
	logic               sat_q;

	logic [DW-1:0]      diff;
	logic [DW-1:0]      mag;
	logic [MAGW-1:0]    mag_ext;
	logic               sq_sat;
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic               div_start;
	logic [DVD_W-1:0]   div_dvd;
	logic [DVS_W-1:0]   div_dvs;
	logic               div_busy;
	logic [DVD_W-1:0]   div_quo;
	logic [DVD_W:0]     y_sum;
	logic [DVD_W-1:0]   y_val;
	logic [SHF_W-1:0]   amt;
	logic               ztop;
	logic [DVD_W-1:0]   yn_next;
	logic [SHF_W-1:0]   shf_next;
	logic [MUL_W-2:0]   m_next;
	logic               fbit;
	logic [LN_W-1:0]    lg;
	logic [MUL_W:0]     rnd;
	logic [SUM_W:0]     acc;
	logic [SUM_W-1:0]   new_sum;
	logic               new_clip;
	logic               out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign cost_sum  = cost_q;
	assign saturated = sat_q;

	// Magnitude of the error; beyond 32 bits the square saturates.
	always_comb begin
		diff    = {data_q[SAMPLE_BITS-1], data_q} - {model_q[SAMPLE_BITS-1], model_q};
		mag     = diff[DW-1] ? (~diff + 1'b1) : diff;
		mag_ext = MAGW'(mag);
		sq_sat  = |mag_ext[MAGW-1:MUL_W];
	end

	// Next mantissa and fraction bit from the registered square.
	always_comb begin
		fbit   = mul_p[2*MUL_W-3];
		m_next = fbit ? mul_p[2*MUL_W-3:MUL_W-1] : mul_p[2*MUL_W-4:MUL_W-2];
		lg     = {K_OFS - shf_q, frac_q};
	end

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = mag_ext[MUL_W-1:0];
		mul_b = mag_ext[MUL_W-1:0];
		case (state_q)
			ST_LOG: begin
				mul_a = (cnt_q == 5'd0) ? {1'b0, yn_q[DVD_W-1:DVD_W-MUL_W+1]} : {1'b0, m_next};
				mul_b = mul_a;
			end
			ST_LN: begin
				mul_a = MUL_W'(lg);
				mul_b = LN2_Q32;
			end
			default: begin
				mul_a = mag_ext[MUL_W-1:0];
				mul_b = mag_ext[MUL_W-1:0];
			end
		endcase
	end

	stcs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// Divider start: square (or its saturated value) over nu, zero taken as one.
	always_comb begin
		div_start = (state_q == ST_DIVS);
		div_dvd   = sq_sat ? '1 : mul_p;
		div_dvs   = (nu_q == '0) ? DVS_W'(1) : nu_q;
	end

	stcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy_q   (div_busy),
		.quo_q    (div_quo)
	);

	// One plus the quotient, saturating at the top of 64 bits.
	always_comb begin
		y_sum = {1'b0, div_quo} + {1'b0, ONE_Q16};
		y_val = y_sum[DVD_W] ? '1 : y_sum[DVD_W-1:0];
	end

	// Binary normalize step: shift out leading zeros in halving chunks.
	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin amt = 6'd32; ztop = (yn_q[63:32] == '0); end
			3'd1: begin amt = 6'd16; ztop = (yn_q[63:48] == '0); end
			3'd2: begin amt = 6'd8;  ztop = (yn_q[63:56] == '0); end
			3'd3: begin amt = 6'd4;  ztop = (yn_q[63:60] == '0); end
			3'd4: begin amt = 6'd2;  ztop = (yn_q[63:62] == '0); end
			3'd5: begin amt = 6'd1;  ztop = !yn_q[63]; end
			default: begin amt = 6'd0; ztop = 1'b0; end
		endcase
		yn_next  = ztop ? (yn_q << amt) : yn_q;
		shf_next = ztop ? (shf_q + amt) : shf_q;
	end

	// Round the scaled log and add it to the running sum with clipping.
	always_comb begin
		rnd      = mul_p[PROD_W-1:MUL_W-1] + (MUL_W + 1)'(1);
		acc      = {1'b0, sum_q} + (SUM_W + 1)'(lnv_q);
		new_sum  = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
		new_clip = clip_q | acc[SUM_W];
		out_free = !out_valid_q || out_ready;
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			clip_q      <= 1'b0;
			nu_q        <= NU_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				nu_q <= cfg_nu;
			end
			// The result register fills on a last pair and empties on a transfer.
			if (state_q == ST_ACC && last_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					state_q <= ST_DIVS;
				end
				ST_DIVS: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_busy) begin
						cnt_q   <= '0;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (cnt_q == 5'd5) begin
						cnt_q   <= '0;
						state_q <= ST_LOG;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LOG: begin
					if (cnt_q == 5'(FRAC_W)) begin
						cnt_q   <= '0;
						state_q <= ST_LN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LN: begin
					state_q <= ST_LNR;
				end
				ST_LNR: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (!last_q) begin
						sum_q   <= new_sum;
						clip_q  <= new_clip;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						sum_q       <= '0;
						clip_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q  <= data_sample;
			model_q <= model_sample;
			last_q  <= last_sample;
		end
		if (state_q == ST_DIV && !div_busy) begin
			yn_q  <= y_val;
			shf_q <= '0;
		end
		if (state_q == ST_NORM) begin
			yn_q  <= yn_next;
			shf_q <= shf_next;
		end
		if (state_q == ST_LOG && cnt_q != 5'd0) begin
			frac_q <= {frac_q[FRAC_W-2:0], fbit};
		end
		if (state_q == ST_LNR) begin
			lnv_q <= rnd[LN_W:1];
		end
		if (state_q == ST_ACC && last_q && out_free) begin
			cost_q <= new_sum;
			sat_q  <= new_clip;
		end
	end

	// A transfer on the input closes the input until the pair is done.
	a_in_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input stayed open after a transfer");

	// The divider only runs while the sequencer waits on it.
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV)
		else $error("divider busy outside its wait state");

	// A new result only comes from a pair marked last.
	a_out_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(last_q) && $past(state_q == ST_ACC))
		else $error("result without a last pair");

	// A clipped sum always shows the full-scale value.
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> cost_sum == '1)
		else $error("saturated result below full scale");

endmodule

`default_nettype wire

// ===== design/stcs_mul.sv =====
`default_nettype none

module stcs_mul
	import stcs_pkg::*;
(
	input  wire                clk,
	input  wire  [MUL_W-1:0]   a,
	input  wire  [MUL_W-1:0]   b,
	output logic [PROD_W-1:0]  p_q
);

	// Unsigned product, registered every cycle.
	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

`default_nettype wire

// ===== design/stcs_div.sv =====
`default_nettype none

module stcs_div
	import stcs_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire  [DVD_W-1:0]   dividend,
	input  wire  [DVS_W-1:0]   divisor,
	output logic               busy_q,
	output logic [DVD_W-1:0]   quo_q
);

	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W:0]       trial;
	logic [DVS_W:0]       diff;
	logic                 fits;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient registers; the quotient shifts in from the dividend.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

endmodule

`default_nettype wire
